>>> src/mic_pkg.sv
// Shared types, register map constants and offset decode for the interrupt controller.
package mic_pkg;

  localparam int unsigned NUM_BANKS  = 4;
  localparam int unsigned BANK_W     = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
  localparam int unsigned NUM_LINES  = NUM_BANKS * 32;
  localparam int unsigned ACT_W      = BANK_W + 5;
  localparam int unsigned LINE_EXT_W = 8;

  localparam logic [11:0] OFS_IDENT    = 12'h000;
  localparam logic [11:0] OFS_SYSCFG   = 12'h010;
  localparam logic [11:0] OFS_SYSSTAT  = 12'h014;
  localparam logic [11:0] OFS_ACTIVE   = 12'h040;
  localparam logic [11:0] OFS_ACTIVE_F = 12'h044;
  localparam logic [11:0] OFS_CTRL     = 12'h048;
  localparam logic [11:0] OFS_PROT     = 12'h04C;
  localparam logic [11:0] OFS_IDLE     = 12'h050;
  localparam logic [11:0] OFS_PRIO_I   = 12'h060;
  localparam logic [11:0] OFS_PRIO_F   = 12'h064;
  localparam logic [11:0] OFS_THRESH   = 12'h068;
  localparam logic [11:0] BANK_BASE    = 12'h080;
  localparam int unsigned BANK_STRIDE  = 32'h20;
  localparam logic [11:0] BANK_END     = 12'(32'h80 + NUM_BANKS * BANK_STRIDE);

  localparam logic [4:0] SUB_STATUS   = 5'h00;
  localparam logic [4:0] SUB_MASK     = 5'h04;
  localparam logic [4:0] SUB_MASK_CLR = 5'h08;
  localparam logic [4:0] SUB_MASK_SET = 5'h0C;
  localparam logic [4:0] SUB_ZERO_A   = 5'h10;
  localparam logic [4:0] SUB_ZERO_B   = 5'h14;
  localparam logic [4:0] SUB_PENDING  = 5'h18;
  localparam logic [4:0] SUB_ZERO_C   = 5'h1C;

  localparam int unsigned SOFT_RESET_BIT = 1;
  localparam logic [31:0] IDENT_VALUE    = 32'h0000_0040;
  localparam logic [31:0] SYSSTAT_VALUE  = 32'h0000_0001;
  localparam logic [31:0] THRESH_VALUE   = 32'h0000_00FF;
  localparam logic [31:0] MASK_RESET     = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    CMD_LINE  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } mic_cmd_e;

  typedef enum logic [3:0] {
    REG_NONE,
    REG_IDENT,
    REG_SYSCFG,
    REG_SYSSTAT,
    REG_ACTIVE,
    REG_ZERO,
    REG_THRESH,
    REG_BK_STATUS,
    REG_BK_MASK,
    REG_BK_MASK_CLR,
    REG_BK_MASK_SET,
    REG_BK_PENDING,
    REG_BK_ZERO
  } mic_reg_e;

  typedef logic [31:0] mic_word_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] offset;
    logic [31:0] write_data;
    logic [6:0]  line;
    logic        level;
  } mic_in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_out;
    logic        bad_offset;
  } mic_out_t;

  typedef struct packed {
    mic_reg_e          kind;
    logic [BANK_W-1:0] bank;
  } mic_dec_t;

  function automatic mic_dec_t mic_decode(input logic [11:0] offset);
    mic_dec_t    dec;
    logic [11:0] rel;
    rel      = offset - BANK_BASE;
    dec.kind = REG_NONE;
    dec.bank = rel[5 +: BANK_W];
    unique case (offset)
      OFS_IDENT:   dec.kind = REG_IDENT;
      OFS_SYSCFG:  dec.kind = REG_SYSCFG;
      OFS_SYSSTAT: dec.kind = REG_SYSSTAT;
      OFS_ACTIVE:  dec.kind = REG_ACTIVE;
      OFS_ACTIVE_F, OFS_CTRL, OFS_PROT, OFS_IDLE, OFS_PRIO_I, OFS_PRIO_F:
        dec.kind = REG_ZERO;
      OFS_THRESH:  dec.kind = REG_THRESH;
      default: begin
        if (offset >= BANK_BASE && offset < BANK_END) begin
          unique case (rel[4:0])
            SUB_STATUS:   dec.kind = REG_BK_STATUS;
            SUB_MASK:     dec.kind = REG_BK_MASK;
            SUB_MASK_CLR: dec.kind = REG_BK_MASK_CLR;
            SUB_MASK_SET: dec.kind = REG_BK_MASK_SET;
            SUB_PENDING:  dec.kind = REG_BK_PENDING;
            SUB_ZERO_A, SUB_ZERO_B, SUB_ZERO_C: dec.kind = REG_BK_ZERO;
            default:      dec.kind = REG_NONE;
          endcase
        end
      end
    endcase
    return dec;
  endfunction

endpackage

>>> src/mic_state.sv
// Line status, mask and config word registers with their update logic.
module mic_state (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  mic_pkg::mic_in_t           item_i,
  output mic_pkg::mic_word_t         status_o [mic_pkg::NUM_BANKS],
  output mic_pkg::mic_word_t         mask_o   [mic_pkg::NUM_BANKS],
  output mic_pkg::mic_word_t         syscfg_o,
  output logic                       irq_o
);
  import mic_pkg::*;

  mic_word_t status_q [NUM_BANKS];
  mic_word_t status_d [NUM_BANKS];
  mic_word_t mask_q   [NUM_BANKS];
  mic_word_t mask_d   [NUM_BANKS];
  mic_word_t syscfg_q, syscfg_d;

  mic_dec_t                dec;
  logic [LINE_EXT_W-1:0]   line_ext;
  logic [BANK_W-1:0]       line_bank;
  logic                    line_ok;

  assign dec       = mic_decode(item_i.offset);
  assign line_ext  = {1'b0, item_i.line};
  assign line_bank = line_ext[5 +: BANK_W];
  assign line_ok   = 32'(line_ext) < NUM_LINES;

  always_comb begin
    status_d = status_q;
    mask_d   = mask_q;
    syscfg_d = syscfg_q;
    if (en_i) begin
      unique case (item_i.command)
        CMD_LINE: begin
          if (line_ok) begin
            status_d[line_bank][item_i.line[4:0]] = item_i.level;
          end
        end
        CMD_WRITE: begin
          unique case (dec.kind)
            REG_SYSCFG: begin
              if (item_i.write_data[SOFT_RESET_BIT]) begin
                // soft reset: restore every register
                for (int b = 0; b < NUM_BANKS; b++) begin
                  status_d[b] = '0;
                  mask_d[b]   = MASK_RESET;
                end
                syscfg_d = '0;
              end else begin
                syscfg_d = item_i.write_data;
              end
            end
            REG_BK_MASK:     mask_d[dec.bank] = item_i.write_data;
            REG_BK_MASK_CLR: mask_d[dec.bank] = mask_q[dec.bank] & ~item_i.write_data;
            REG_BK_MASK_SET: mask_d[dec.bank] = mask_q[dec.bank] | item_i.write_data;
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    irq_o = 1'b0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      irq_o = irq_o | (|(status_d[b] & ~mask_d[b]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < NUM_BANKS; b++) begin
        status_q[b] <= '0;
        mask_q[b]   <= MASK_RESET;
      end
      syscfg_q <= '0;
    end else begin
      status_q <= status_d;
      mask_q   <= mask_d;
      syscfg_q <= syscfg_d;
    end
  end

  assign status_o = status_q;
  assign mask_o   = mask_q;
  assign syscfg_o = syscfg_q;

endmodule

>>> src/mic_read.sv
// Register read mux, active-line priority encoder and offset error flag.
module mic_read (
  input  mic_pkg::mic_in_t   item_i,
  input  mic_pkg::mic_word_t status_i [mic_pkg::NUM_BANKS],
  input  mic_pkg::mic_word_t mask_i   [mic_pkg::NUM_BANKS],
  input  mic_pkg::mic_word_t syscfg_i,
  output logic [31:0]        read_data_o,
  output logic               bad_offset_o
);
  import mic_pkg::*;

  mic_dec_t          dec;
  mic_word_t         pend     [NUM_BANKS];
  logic [4:0]        low_bit  [NUM_BANKS];
  logic [NUM_BANKS-1:0] bank_hit;
  logic [ACT_W-1:0]  active;
  logic              is_bus;

  assign dec    = mic_decode(item_i.offset);
  assign is_bus = (item_i.command == CMD_READ) || (item_i.command == CMD_WRITE);

  // lowest set bit in each bank
  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      pend[b]     = status_i[b] & ~mask_i[b];
      bank_hit[b] = |pend[b];
      low_bit[b]  = '0;
      for (int k = 31; k >= 0; k--) begin
        if (pend[b][k]) low_bit[b] = 5'(k);
      end
    end
  end

  // lowest bank with anything pending; zero when nothing is
  always_comb begin
    active = '0;
    for (int b = NUM_BANKS - 1; b >= 0; b--) begin
      if (bank_hit[b]) active = {BANK_W'(b), low_bit[b]};
    end
  end

  always_comb begin
    read_data_o = '0;
    if (item_i.command == CMD_READ) begin
      unique case (dec.kind)
        REG_IDENT:       read_data_o = IDENT_VALUE;
        REG_SYSCFG:      read_data_o = syscfg_i;
        REG_SYSSTAT:     read_data_o = SYSSTAT_VALUE;
        REG_ACTIVE:      read_data_o = 32'(active);
        REG_THRESH:      read_data_o = THRESH_VALUE;
        REG_BK_STATUS:   read_data_o = status_i[dec.bank];
        REG_BK_MASK, REG_BK_MASK_CLR, REG_BK_MASK_SET:
                         read_data_o = mask_i[dec.bank];
        REG_BK_PENDING:  read_data_o = pend[dec.bank];
        default:         read_data_o = '0;
      endcase
    end
  end

  assign bad_offset_o = is_bus && (dec.kind == REG_NONE);

endmodule

>>> src/masked_interrupt_controller.sv
// Top level of the masked interrupt controller: input and result registers.
//
// Input channel (in_valid_i / in_stall_o / in_item_i) carries one transaction
// per item: a line level change, a 32-bit register read or a 32-bit write.
// Output channel (out_valid_o / out_stall_i / out_item_o) returns exactly one
// result per item: read data, the parent IRQ level after the item, and a flag
// for an undecoded offset.
// An accepted item lands in the input register; when the result register can
// take it, the decode, the state update and the 128-line priority encoder run
// in one pass and the result is written to the output register. Throughput is
// one item per cycle while the receiver does not stall, set by the single pass
// through the encoder and read mux.
// When the receiver stalls, the result register holds its transaction and the
// input register holds one more item; in_stall_o then rises until the result
// drains. State changes only when an item moves into the result register.
// Asynchronous reset clears both registers' valid flags, the status and
// config words, and sets every mask bit. A write of the soft-reset bit to the
// config register does the same to the state, in line with item order.
module masked_interrupt_controller (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mic_pkg::mic_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output mic_pkg::mic_out_t out_item_o
);
  import mic_pkg::*;

  logic      in_valid_q, in_valid_d;
  mic_in_t   in_item_q;
  logic      out_valid_q, out_valid_d;
  mic_out_t  out_item_q, out_item_d;
  logic      advance;
  logic      load;

  mic_word_t status [NUM_BANKS];
  mic_word_t mask   [NUM_BANKS];
  mic_word_t syscfg;
  logic      irq_next;
  logic [31:0] read_data;
  logic      bad_offset;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign load       = in_valid_i && !in_stall_o;

  assign in_valid_d  = load || (in_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  mic_state u_state (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (in_item_q),
    .status_o (status),
    .mask_o   (mask),
    .syscfg_o (syscfg),
    .irq_o    (irq_next)
  );

  mic_read u_read (
    .item_i       (in_item_q),
    .status_i     (status),
    .mask_i       (mask),
    .syscfg_i     (syscfg),
    .read_data_o  (read_data),
    .bad_offset_o (bad_offset)
  );

  always_comb begin
    out_item_d            = out_item_q;
    if (advance) begin
      out_item_d.read_data  = read_data;
      out_item_d.irq_out    = irq_next;
      out_item_d.bad_offset = bad_offset;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers: load on accept, hold otherwise
  always_ff @(posedge clk_i) begin
    if (load) begin
      in_item_q <= in_item_i;
    end
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the masked interrupt controller.
module testbench;
  import mic_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;
  localparam int LONG_HOLD = 300;
  localparam int PHASE_ITEMS = 250;
  localparam longint RUN_LIMIT = 64'd4_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  mic_in_t in_item = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  mic_out_t out_item;

  // controller state as seen by the checker
  mic_word_t cfg_word;
  mic_word_t line_lvl [NUM_BANKS];
  mic_word_t line_msk [NUM_BANKS];

  mic_out_t due_responses [$];
  int fail_count = 0;
  int responses_seen = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_requests = 0;
  int holds_started = 0;
  int hold_left = 0;

  masked_interrupt_controller u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void clear_state();
    cfg_word = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      line_lvl[b] = '0;
      line_msk[b] = MASK_RESET;
    end
  endfunction

  function automatic logic unmasked_pending();
    for (int b = 0; b < NUM_BANKS; b++)
      if ((line_lvl[b] & ~line_msk[b]) != '0) return 1'b1;
    return 1'b0;
  endfunction

  function automatic mic_word_t lowest_open_line();
    for (int n = 0; n < NUM_LINES; n++)
      if (line_lvl[n / 32][n % 32] && !line_msk[n / 32][n % 32]) return mic_word_t'(n);
    return '0;
  endfunction

  // Returns 1 when the offset decodes; reads and writes share one map.
  function automatic logic bus_access(input logic wr, input logic [11:0] ofs,
                                      input mic_word_t wdata, output mic_word_t rdata);
    logic [11:0] rel;
    int unsigned bk;
    logic ok;
    rel = ofs - BANK_BASE;
    bk = rel / BANK_STRIDE;
    rdata = '0;
    ok = 1'b1;
    case (ofs)
      OFS_IDENT:   rdata = IDENT_VALUE;
      OFS_SYSCFG: begin
        rdata = cfg_word;
        if (wr) begin
          if (wdata[SOFT_RESET_BIT]) clear_state();
          else cfg_word = wdata;
        end
      end
      OFS_SYSSTAT: rdata = SYSSTAT_VALUE;
      OFS_ACTIVE:  rdata = lowest_open_line();
      OFS_ACTIVE_F, OFS_CTRL, OFS_PROT, OFS_IDLE, OFS_PRIO_I, OFS_PRIO_F: ;
      OFS_THRESH:  rdata = THRESH_VALUE;
      default: begin
        if (ofs >= BANK_BASE && ofs < BANK_END) begin
          case (rel[4:0])
            SUB_STATUS:  rdata = line_lvl[bk];
            SUB_MASK: begin
              rdata = line_msk[bk];
              if (wr) line_msk[bk] = wdata;
            end
            SUB_MASK_CLR: begin
              rdata = line_msk[bk];
              if (wr) line_msk[bk] &= ~wdata;
            end
            SUB_MASK_SET: begin
              rdata = line_msk[bk];
              if (wr) line_msk[bk] |= wdata;
            end
            SUB_PENDING: rdata = line_lvl[bk] & ~line_msk[bk];
            SUB_ZERO_A, SUB_ZERO_B, SUB_ZERO_C: ;
            default: ok = 1'b0;
          endcase
        end else begin
          ok = 1'b0;
        end
      end
    endcase
    if (!ok || wr) rdata = '0;
    return ok;
  endfunction

  function automatic mic_out_t response_for(input mic_in_t it);
    mic_out_t r;
    mic_word_t rd;
    r = '0;
    case (it.command)
      CMD_LINE: begin
        if (it.line < NUM_LINES) line_lvl[it.line / 32][it.line % 32] = it.level;
      end
      CMD_READ: begin
        r.bad_offset = !bus_access(1'b0, it.offset, it.write_data, rd);
        r.read_data = rd;
      end
      CMD_WRITE: r.bad_offset = !bus_access(1'b1, it.offset, it.write_data, rd);
      default: ;
    endcase
    r.irq_out = unmasked_pending();
    return r;
  endfunction

  // Unused fields carry random values so every input bit toggles.
  function automatic mic_in_t make_item(input logic [1:0] cmd, input logic [11:0] ofs,
                                        input mic_word_t data, input logic [6:0] ln,
                                        input logic lvl);
    mic_in_t it;
    it.command = cmd;
    it.offset = (cmd == CMD_LINE) ? 12'($urandom) : ofs;
    it.write_data = (cmd == CMD_WRITE) ? data : $urandom;
    it.line = (cmd == CMD_LINE) ? ln : 7'($urandom);
    it.level = (cmd == CMD_LINE) ? lvl : 1'($urandom);
    return it;
  endfunction

  function automatic logic [11:0] bank_offset(input int unsigned bk, input logic [4:0] sub);
    return BANK_BASE + 12'(bk * BANK_STRIDE) + 12'(sub);
  endfunction

  function automatic logic [11:0] decoded_offset();
    if ($urandom_range(1))
      return bank_offset($urandom_range(NUM_BANKS - 1), 5'($urandom_range(7) * 4));
    case ($urandom_range(9))
      0:       return OFS_IDENT;
      1:       return OFS_SYSCFG;
      2:       return OFS_SYSSTAT;
      3:       return OFS_ACTIVE_F;
      4:       return OFS_CTRL;
      5:       return OFS_PROT;
      6:       return OFS_IDLE;
      7:       return ($urandom_range(1)) ? OFS_PRIO_I : OFS_PRIO_F;
      8:       return OFS_THRESH;
      default: return OFS_ACTIVE;
    endcase
  endfunction

  function automatic mic_in_t random_item();
    int unsigned pick;
    logic [4:0] sub;
    pick = $urandom_range(99);
    if (pick < 35)
      return make_item(CMD_LINE, '0, '0, 7'($urandom), 1'($urandom));
    if (pick < 60)
      return make_item(CMD_READ, decoded_offset(), '0, '0, 1'b0);
    if (pick < 80) begin
      case ($urandom_range(2))
        0:       sub = SUB_MASK;
        1:       sub = SUB_MASK_CLR;
        default: sub = SUB_MASK_SET;
      endcase
      return make_item(CMD_WRITE, bank_offset($urandom_range(NUM_BANKS - 1), sub),
                       $urandom & $urandom, '0, 1'b0);
    end
    if (pick < 83)
      return make_item(CMD_WRITE, OFS_SYSCFG, $urandom, '0, 1'b0);
    if (pick < 88)
      return make_item(CMD_WRITE, decoded_offset(), $urandom, '0, 1'b0);
    if (pick < 97)
      return make_item(($urandom_range(1)) ? CMD_READ : CMD_WRITE, 12'($urandom),
                       $urandom, '0, 1'b0);
    return make_item(CMD_SPARE, 12'($urandom), $urandom, 7'($urandom), 1'($urandom));
  endfunction

  // Drive at the rising edge, look at the stall at the falling edge, where it is
  // settled for the next rising edge.
  task automatic send_item(input mic_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(negedge clk);
    while (in_stall) @(negedge clk);
    @(posedge clk);
    items_sent++;
  endtask

  // Predict on every accepted transaction; the handshake is sampled at the
  // falling edge before the accepting rising edge.
  always @(negedge clk) begin
    if (rst_n && in_valid && !in_stall) due_responses.push_back(response_for(in_item));
  end

  always @(negedge clk) begin
    mic_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_responses.size() == 0) begin
        $error("unexpected result transaction: %p", out_item);
        fail_count++;
      end else begin
        want = due_responses.pop_front();
        responses_seen++;
        if (out_item.read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, out_item.read_data);
          fail_count++;
        end
        if (out_item.irq_out !== want.irq_out) begin
          $error("irq_out: expected %b, got %b", want.irq_out, out_item.irq_out);
          fail_count++;
        end
        if (out_item.bad_offset !== want.bad_offset) begin
          $error("bad_offset: expected %b, got %b", want.bad_offset, out_item.bad_offset);
          fail_count++;
        end
      end
    end
  end

  // Receiver stall; a hold-off request keeps it high until hold_left counts down from LONG_HOLD.
  always @(posedge clk) begin
    if (hold_requests != holds_started) begin
      holds_started = hold_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic test_register_map();
    send_idle_pct = 0;
    stall_pct = 0;
    send_item(make_item(CMD_READ, OFS_IDENT, '0, '0, 1'b0));
    send_item(make_item(CMD_READ, OFS_ACTIVE, '0, '0, 1'b0));
    // active reads 0 with nothing pending and again with line 0 asserted and unmasked
    send_item(make_item(CMD_LINE, '0, '0, 7'd0, 1'b1));
    send_item(make_item(CMD_WRITE, bank_offset(0, SUB_MASK_CLR), 32'h1, '0, 1'b0));
    send_item(make_item(CMD_READ, OFS_ACTIVE, '0, '0, 1'b0));
    send_item(make_item(CMD_LINE, '0, '0, 7'd127, 1'b1));
    send_item(make_item(CMD_WRITE, bank_offset(NUM_BANKS - 1, SUB_MASK), '0, '0, 1'b0));
    send_item(make_item(CMD_LINE, '0, '0, 7'd0, 1'b0));
    send_item(make_item(CMD_READ, OFS_ACTIVE, '0, '0, 1'b0));
    send_item(make_item(CMD_READ, bank_offset(NUM_BANKS - 1, SUB_PENDING), '0, '0, 1'b0));
    send_item(make_item(CMD_WRITE, bank_offset(NUM_BANKS - 1, SUB_MASK_SET), '1, '0, 1'b0));
    send_item(make_item(CMD_READ, bank_offset(NUM_BANKS - 1, SUB_STATUS), '0, '0, 1'b0));
    send_item(make_item(CMD_WRITE, OFS_SYSCFG, 32'hFFFF_FFFD, '0, 1'b0));
    send_item(make_item(CMD_READ, OFS_SYSCFG, '0, '0, 1'b0));
    send_item(make_item(CMD_READ, OFS_SYSSTAT, '0, '0, 1'b0));
    send_item(make_item(CMD_READ, OFS_THRESH, '0, '0, 1'b0));
    send_item(make_item(CMD_READ, OFS_PRIO_F, '0, '0, 1'b0));
    send_item(make_item(CMD_WRITE, OFS_IDENT, '1, '0, 1'b0));
    // undecoded: hole in the fixed map, unaligned in a bank, past the banks, top
    send_item(make_item(CMD_READ, 12'h004, '0, '0, 1'b0));
    send_item(make_item(CMD_READ, bank_offset(0, 5'h02), '0, '0, 1'b0));
    send_item(make_item(CMD_WRITE, BANK_END, '1, '0, 1'b0));
    send_item(make_item(CMD_READ, 12'hFFF, '0, '0, 1'b0));
    send_item(make_item(CMD_SPARE, '1, '1, '1, 1'b1));
    // soft reset drops the config word and masks every line again
    send_item(make_item(CMD_WRITE, OFS_SYSCFG, 32'h2, '0, 1'b0));
    send_item(make_item(CMD_READ, OFS_SYSCFG, '0, '0, 1'b0));
    send_item(make_item(CMD_READ, bank_offset(0, SUB_MASK), '0, '0, 1'b0));
  endtask

  task automatic test_random_traffic(input int count, input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct = stall;
    repeat (count) send_item(random_item());
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_requests++;
    repeat (30) send_item(random_item());
  endtask

  initial begin
    #(RUN_LIMIT);
    $display("masked_interrupt_controller test failed");
    $finish;
  end

  initial begin
    clear_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_register_map();
    test_random_traffic(PHASE_ITEMS, 0, 0);
    test_random_traffic(PHASE_ITEMS, 56, 0);
    test_random_traffic(PHASE_ITEMS, 0, 56);
    test_random_traffic(PHASE_ITEMS, 20, 20);
    test_backpressure();
    in_valid <= 1'b0;
    stall_pct = 0;
    while (due_responses.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Sent %0d transactions, checked %0d results.", items_sent, responses_seen);
    $display("Covered register map, masks, soft reset, bad offsets, idle mixes and a %0d-cycle hold.",
             LONG_HOLD);
    if (fail_count == 0) begin
      $display("masked_interrupt_controller test passed");
    end else begin
      $display("masked_interrupt_controller test failed");
    end
    $finish;
  end

endmodule
